// ===== src/gdfs_pkg.sv =====
package gdfs_pkg;

   // default epoch: midnight on january 1 of this year
   localparam int EPOCH_YEAR_DEFAULT = 1900;

   localparam logic [31:0] DAY_SECONDS    = 32'd86400;
   localparam logic [31:0] HOUR_SECONDS   = 32'd3600;
   localparam logic [31:0] MINUTE_SECONDS = 32'd60;
   localparam logic [31:0] COMMON_YEAR    = 32'd365;
   localparam logic [31:0] LEAP_YEAR      = 32'd366;

   localparam logic [3:0] MONTH_FEB  = 4'd1;
   localparam logic [3:0] MONTH_LAST = 4'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAYDIV,
      ST_HOURDIV,
      ST_MINDIV,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } state_type;

   // days in a month of a common year, month counted from 0
   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd1:                      len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // remainder by 7 of a 9-bit value, reciprocal multiply then correction-free
   function automatic logic [2:0] mod7(input logic [8:0] v);
      logic [17:0] prod;
      logic [8:0]  quot;
      logic [8:0]  rem;
      prod = 18'(v) * 18'd293;
      quot = 9'(prod >> 11);
      rem  = v - 9'(quot * 9'd7);
      return rem[2:0];
   endfunction

endpackage

// ===== src/gregorian_datetime_from_seconds.sv =====
// seconds count to gregorian calendar date and time of day
//
// req channel carries one word: a 32-bit unsigned count of seconds since
// midnight on january 1 of EPOCH_YEAR (leap seconds ignored). rsp channel
// carries one word per request: second, minute, hour, day of month, month,
// year, weekday (0 is sunday) and day of year.
//
// one shared compare-subtract unit does all the work under a small
// sequencer: restoring division by 86400 for the day count, then by 3600
// for the hour and by 60 for the minute, then a loop that takes off one
// elapsed year at a time, a loop that takes off one elapsed month at a
// time, and a final load. req_ready rises again together with rsp_valid,
// so a new request is taken only once the last one is finished; the
// year loop is the longest part of the work.
//
// reset (synchronous) returns the sequencer to idle and drops rsp_valid.
// the finished word sits in an output register: a stalled receiver does
// not stop the next request from being taken and worked on, but the
// sequencer waits in its final cycle until the held word has gone.
module gregorian_datetime_from_seconds #(
   parameter int EPOCH_YEAR = gdfs_pkg::EPOCH_YEAR_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_seconds_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_number,
   output logic [10:0] rsp_year_number,
   output logic [2:0]  rsp_weekday,
   output logic [8:0]  rsp_day_of_year
);

   // calendar state of the epoch, worked out at elaboration
   localparam int PRIOR_YEAR = EPOCH_YEAR - 1;
   localparam logic [1:0] EPOCH_MOD4   = 2'(EPOCH_YEAR % 4);
   localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
   localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);
   localparam logic [11:0] EPOCH_Y     = 12'(EPOCH_YEAR);
   // weekday of january 1 of the epoch year
   localparam logic [2:0] EPOCH_WD =
      3'((PRIOR_YEAR + PRIOR_YEAR / 4 - PRIOR_YEAR / 100 + PRIOR_YEAR / 400 + 1) % 7);

   gdfs_pkg::state_type state_ff, state_in;

   // working registers
   logic [31:0] rem_ff,    rem_in;     // seconds remainder
   logic [15:0] days_ff,   days_in;    // day count, then day within year/month
   logic [4:0]  hour_ff,   hour_in;
   logic [5:0]  min_ff,    min_in;
   logic [3:0]  step_ff,   step_in;    // quotient bit under test
   logic [11:0] year_ff,   year_in;
   logic [1:0]  mod4_ff,   mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;
   logic [2:0]  wd_ff,     wd_in;
   logic [8:0]  yday_ff,   yday_in;
   logic [3:0]  month_ff,  month_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  sec_out_ff,   sec_out_in;
   logic [5:0]  min_out_ff,   min_out_in;
   logic [4:0]  hour_out_ff,  hour_out_in;
   logic [4:0]  dom_out_ff,   dom_out_in;
   logic [3:0]  mon_out_ff,   mon_out_in;
   logic [10:0] year_out_ff,  year_out_in;
   logic [2:0]  wd_out_ff,    wd_out_in;
   logic [8:0]  yday_out_ff,  yday_out_in;

   // shared compare-subtract unit
   logic [31:0] sub_a, sub_b;
   logic [32:0] sub_diff;
   logic        sub_borrow;

   logic        accept;
   logic        out_free;
   logic        is_leap;
   logic [8:0]  year_len;
   logic [4:0]  cur_month_len;
   logic [3:0]  wd_sum;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // gregorian rule from the running remainders of the year
   assign is_leap  = (mod100_ff != 7'd0) ? (mod4_ff == 2'd0) : (mod400_ff == 9'd0);
   assign year_len = is_leap ? gdfs_pkg::LEAP_YEAR[8:0] : gdfs_pkg::COMMON_YEAR[8:0];
   assign cur_month_len = gdfs_pkg::month_len(month_ff)
                        + {4'd0, (month_ff == gdfs_pkg::MONTH_FEB) && is_leap};

   // operand selection for the shared unit
   always_comb begin
      sub_a = rem_ff;
      sub_b = '0;
      unique case (state_ff)
         gdfs_pkg::ST_DAYDIV:  sub_b = gdfs_pkg::DAY_SECONDS << step_ff;
         gdfs_pkg::ST_HOURDIV: sub_b = gdfs_pkg::HOUR_SECONDS << step_ff;
         gdfs_pkg::ST_MINDIV:  sub_b = gdfs_pkg::MINUTE_SECONDS << step_ff;
         gdfs_pkg::ST_YEAR: begin
            sub_a = {16'd0, days_ff};
            sub_b = {23'd0, year_len};
         end
         gdfs_pkg::ST_MONTH: begin
            sub_a = {16'd0, days_ff};
            sub_b = {27'd0, cur_month_len};
         end
         default: begin
            sub_a = rem_ff;
            sub_b = '0;
         end
      endcase
   end

   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[32];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdfs_pkg::ST_IDLE:    if (accept) state_in = gdfs_pkg::ST_DAYDIV;
         gdfs_pkg::ST_DAYDIV:  if (step_ff == 4'd0) state_in = gdfs_pkg::ST_HOURDIV;
         gdfs_pkg::ST_HOURDIV: if (step_ff == 4'd0) state_in = gdfs_pkg::ST_MINDIV;
         gdfs_pkg::ST_MINDIV:  if (step_ff == 4'd0) state_in = gdfs_pkg::ST_YEAR;
         gdfs_pkg::ST_YEAR:    if (sub_borrow) state_in = gdfs_pkg::ST_MONTH;
         gdfs_pkg::ST_MONTH: begin
            if (sub_borrow || month_ff == gdfs_pkg::MONTH_LAST) state_in = gdfs_pkg::ST_FINISH;
         end
         gdfs_pkg::ST_FINISH:  if (out_free) state_in = gdfs_pkg::ST_IDLE;
         default:              state_in = gdfs_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      rem_in    = rem_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      min_in    = min_ff;
      step_in   = step_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      wd_in     = wd_ff;
      yday_in   = yday_ff;
      month_in  = month_ff;
      wd_sum    = {1'b0, wd_ff} + (is_leap ? 4'd2 : 4'd1);

      sec_out_in  = sec_out_ff;
      min_out_in  = min_out_ff;
      hour_out_in = hour_out_ff;
      dom_out_in  = dom_out_ff;
      mon_out_in  = mon_out_ff;
      year_out_in = year_out_ff;
      wd_out_in   = wd_out_ff;
      yday_out_in = yday_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         gdfs_pkg::ST_IDLE: begin
            if (accept) begin
               rem_in    = req_seconds_count;
               step_in   = 4'd15;
               year_in   = EPOCH_Y;
               mod4_in   = EPOCH_MOD4;
               mod100_in = EPOCH_MOD100;
               mod400_in = EPOCH_MOD400;
               wd_in     = EPOCH_WD;
            end
         end
         gdfs_pkg::ST_DAYDIV: begin
            if (!sub_borrow) rem_in = sub_diff[31:0];
            days_in = {days_ff[14:0], !sub_borrow};
            step_in = (step_ff == 4'd0) ? 4'd4 : step_ff - 4'd1;
         end
         gdfs_pkg::ST_HOURDIV: begin
            if (!sub_borrow) rem_in = sub_diff[31:0];
            hour_in = {hour_ff[3:0], !sub_borrow};
            step_in = (step_ff == 4'd0) ? 4'd5 : step_ff - 4'd1;
         end
         gdfs_pkg::ST_MINDIV: begin
            if (!sub_borrow) rem_in = sub_diff[31:0];
            min_in  = {min_ff[4:0], !sub_borrow};
            step_in = step_ff - 4'd1;
         end
         gdfs_pkg::ST_YEAR: begin
            if (!sub_borrow) begin
               // one more whole year gone: weekday moves on by year length mod 7
               days_in   = sub_diff[15:0];
               year_in   = year_ff + 12'd1;
               mod4_in   = mod4_ff + 2'd1;
               mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
               wd_in     = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
            end else begin
               yday_in  = days_ff[8:0] + 9'd1;
               wd_in    = gdfs_pkg::mod7({6'd0, wd_ff} + days_ff[8:0]);
               month_in = 4'd0;
            end
         end
         gdfs_pkg::ST_MONTH: begin
            if (!sub_borrow && month_ff != gdfs_pkg::MONTH_LAST) begin
               days_in  = sub_diff[15:0];
               month_in = month_ff + 4'd1;
            end
         end
         gdfs_pkg::ST_FINISH: begin
            if (out_free) begin
               sec_out_in   = rem_ff[5:0];
               min_out_in   = min_ff;
               hour_out_in  = hour_ff;
               dom_out_in   = days_ff[4:0] + 5'd1;
               mon_out_in   = month_ff + 4'd1;
               year_out_in  = year_ff[10:0];
               wd_out_in    = wd_ff;
               yday_out_in  = yday_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdfs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      days_ff     <= days_in;
      hour_ff     <= hour_in;
      min_ff      <= min_in;
      step_ff     <= step_in;
      year_ff     <= year_in;
      mod4_ff     <= mod4_in;
      mod100_ff   <= mod100_in;
      mod400_ff   <= mod400_in;
      wd_ff       <= wd_in;
      yday_ff     <= yday_in;
      month_ff    <= month_in;
      sec_out_ff  <= sec_out_in;
      min_out_ff  <= min_out_in;
      hour_out_ff <= hour_out_in;
      dom_out_ff  <= dom_out_in;
      mon_out_ff  <= mon_out_in;
      year_out_ff <= year_out_in;
      wd_out_ff   <= wd_out_in;
      yday_out_ff <= yday_out_in;
   end

   assign req_ready            = (state_ff == gdfs_pkg::ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_second_of_minute = sec_out_ff;
   assign rsp_minute_of_hour   = min_out_ff;
   assign rsp_hour_of_day      = hour_out_ff;
   assign rsp_day_of_month     = dom_out_ff;
   assign rsp_month_number     = mon_out_ff;
   assign rsp_year_number      = year_out_ff;
   assign rsp_weekday          = wd_out_ff;
   assign rsp_day_of_year      = yday_out_ff;

   // day division leaves a proper remainder for the hour step
   a_day_rem : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfs_pkg::ST_HOURDIV) |-> (rem_ff < gdfs_pkg::DAY_SECONDS))
      else $error("remainder after day division out of range");

   // hour division leaves less than an hour for the minute step
   a_hour_rem : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfs_pkg::ST_MINDIV) |-> (rem_ff < gdfs_pkg::HOUR_SECONDS))
      else $error("remainder after hour division out of range");

   // year loop leaves less than a year of days
   a_year_days : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfs_pkg::ST_MONTH) |-> (days_ff < 16'(gdfs_pkg::LEAP_YEAR)
         && month_ff <= gdfs_pkg::MONTH_LAST))
      else $error("month walk started with too many days");

   // a finished word is loaded and the sequencer frees up together
   a_finish_load : assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdfs_pkg::ST_FINISH && out_free)
         |=> (rsp_valid_ff && state_ff == gdfs_pkg::ST_IDLE))
      else $error("finished word not loaded");

endmodule

// ===== sim/gregorian_datetime_from_seconds_test.sv =====
`timescale 1ns / 100ps

module gregorian_datetime_from_seconds_test;

   // expected calendar word, field widths as on the rsp ports
   typedef struct packed {
      logic [5:0]  second_of_minute;
      logic [5:0]  minute_of_hour;
      logic [4:0]  hour_of_day;
      logic [4:0]  day_of_month;
      logic [3:0]  month_number;
      logic [10:0] year_number;
      logic [2:0]  weekday;
      logic [8:0]  day_of_year;
   } datetime_type;

   localparam int unsigned EPOCH = gdfs_pkg::EPOCH_YEAR_DEFAULT;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_seconds_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_second_of_minute;
   logic [5:0]  rsp_minute_of_hour;
   logic [4:0]  rsp_hour_of_day;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month_number;
   logic [10:0] rsp_year_number;
   logic [2:0]  rsp_weekday;
   logic [8:0]  rsp_day_of_year;

   // calendar words predicted for accepted requests, oldest first
   datetime_type pending_dates[$];
   int        error_count   = 0;
   // gaps on both sides switched off for back-to-back stretches
   bit        gaps_enabled  = 1'b1;
   // long receiver hold-off, counted down by the receiver process
   int        holdoff_cycles = 0;

   gregorian_datetime_from_seconds u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_seconds_count    (req_seconds_count),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_number     (rsp_month_number),
      .rsp_year_number      (rsp_year_number),
      .rsp_weekday          (rsp_weekday),
      .rsp_day_of_year      (rsp_day_of_year)
   );

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // gregorian rule: every fourth year, centuries only every fourth one
   function automatic bit leap_year(input int unsigned yr);
      if (yr % 100 != 0)
         return (yr % 4) == 0;
      return (yr % 400) == 0;
   endfunction

   function automatic int unsigned days_in_year(input int unsigned yr);
      return leap_year(yr) ? 366 : 365;
   endfunction

   // walk years then months from the epoch, weekday from the proleptic day count
   function automatic datetime_type predict_datetime(input logic [31:0] secs);
      int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      int unsigned days;
      int unsigned yr;
      int unsigned yday;
      int unsigned mon;
      int unsigned len;
      int unsigned prev;
      datetime_type word;
      days = secs / 86400;
      yr   = EPOCH;
      while (days >= days_in_year(yr)) begin
         days -= days_in_year(yr);
         yr++;
      end
      yday = days + 1;
      mon  = 0;
      while (mon < 11) begin
         len = month_days[mon];
         if (mon == 1 && leap_year(yr))
            len++;
         if (days < len)
            break;
         days -= len;
         mon++;
      end
      prev = yr - 1;
      word.second_of_minute = 6'(secs % 60);
      word.minute_of_hour   = 6'((secs / 60) % 60);
      word.hour_of_day      = 5'((secs / 3600) % 24);
      word.day_of_month     = 5'(days + 1);
      word.month_number     = 4'(mon + 1);
      word.year_number      = 11'(yr);
      word.weekday          = 3'((prev + prev / 4 - prev / 100 + prev / 400 + yday) % 7);
      word.day_of_year      = 9'(yday);
      return word;
   endfunction

   // seconds count for a given year, zero-based day of year and second of day
   function automatic logic [31:0] date_seconds(input int unsigned yr,
                                                input int unsigned day_index,
                                                input int unsigned sec_of_day);
      longint unsigned days;
      days = day_index;
      for (int unsigned y = EPOCH; y < yr; y++)
         days += days_in_year(y);
      return 32'(days * 86400 + sec_of_day);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int next_gap();
      int r;
      if (!gaps_enabled)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(20, 70);
   endfunction

   task automatic check_field(input string name, input int unsigned expected,
                              input int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         error_count++;
      end
   endtask

   // monitor: requests are predicted as they are taken, responses checked in order
   always @(posedge clock) begin
      datetime_type exp_word;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_dates.push_back(predict_datetime(req_seconds_count));
         if (rsp_valid && rsp_ready) begin
            if (pending_dates.size() == 0) begin
               $error("response word with nothing outstanding");
               error_count++;
            end else begin
               exp_word = pending_dates.pop_front();
               check_field("second_of_minute", exp_word.second_of_minute,
                           rsp_second_of_minute);
               check_field("minute_of_hour", exp_word.minute_of_hour, rsp_minute_of_hour);
               check_field("hour_of_day", exp_word.hour_of_day, rsp_hour_of_day);
               check_field("day_of_month", exp_word.day_of_month, rsp_day_of_month);
               check_field("month_number", exp_word.month_number, rsp_month_number);
               check_field("year_number", exp_word.year_number, rsp_year_number);
               check_field("weekday", exp_word.weekday, rsp_weekday);
               check_field("day_of_year", exp_word.day_of_year, rsp_day_of_year);
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_cycles > 0) begin
            rsp_ready = 1'b0;
            holdoff_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = next_gap();
         end
      end
   end

   // offer one word at a falling edge and hold it until it is taken;
   // valid stays high afterwards so a following word can go back to back
   task automatic send_seconds(input logic [31:0] secs);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_seconds_count = secs;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
   endtask

   // field extremes, time-of-day rollovers, leap days and year ends
   task automatic test_directed_edges();
      send_seconds(32'd0);
      send_seconds(32'd59);
      send_seconds(32'd60);
      send_seconds(32'd3599);
      send_seconds(32'd3600);
      send_seconds(32'd86399);
      send_seconds(32'd86400);
      send_seconds(32'h7FFF_FFFF);
      send_seconds(32'h8000_0000);
      send_seconds(32'hFFFF_FFFF);
      // 1900 is a century year without a leap day
      send_seconds(date_seconds(1900, 58, 86399));
      send_seconds(date_seconds(1900, 59, 0));
      send_seconds(date_seconds(1900, 364, 86399));
      // ordinary leap year: feb 29 and the 366th day
      send_seconds(date_seconds(1904, 59, 43200));
      send_seconds(date_seconds(1904, 365, 86399));
      send_seconds(date_seconds(1905, 0, 0));
      // 2000 is a century leap year
      send_seconds(date_seconds(1999, 364, 86399));
      send_seconds(date_seconds(2000, 59, 1));
      send_seconds(date_seconds(2000, 365, 86399));
      send_seconds(date_seconds(2036, 0, 0));
      req_valid = 1'b0;
   endtask

   // mixed random counts: full range, near year and month borders, small values
   task automatic test_random_seconds(input int count);
      int unsigned yr;
      int unsigned day_index;
      logic [31:0] secs;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               yr = $urandom_range(EPOCH, 2035);
               case ($urandom_range(0, 3))
                  0: day_index = 0;
                  1: day_index = 58;
                  2: day_index = 59;
                  default: day_index = days_in_year(yr) - 1;
               endcase
               secs = date_seconds(yr, day_index, $urandom_range(0, 86399));
            end
            1: secs = $urandom_range(0, 200000);
            default: secs = $urandom;
         endcase
         send_seconds(secs);
      end
      req_valid = 1'b0;
   endtask

   // no gaps on either side
   task automatic test_back_to_back(input int count);
      gaps_enabled = 1'b0;
      for (int i = 0; i < count; i++)
         send_seconds($urandom);
      req_valid    = 1'b0;
      gaps_enabled = 1'b1;
   endtask

   // receiver holds off long enough for the block to fill and drop req_ready
   task automatic test_receiver_holdoff();
      gaps_enabled   = 1'b0;
      holdoff_cycles = 800;
      for (int i = 0; i < 8; i++)
         send_seconds($urandom);
      req_valid = 1'b0;
      wait (holdoff_cycles == 0);
      gaps_enabled = 1'b1;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_seconds_count = 32'd0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_random_seconds(440);
      test_back_to_back(40);
      test_receiver_holdoff();
      test_random_seconds(20);

      // drain, then allow a full conversion time for anything stray
      wait (pending_dates.size() == 0);
      repeat (250) @(negedge clock);

      if (error_count == 0 && pending_dates.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
